@@ hdl/scqf_pkg.sv @@
// Shared types and constants of the strip cluster quality filter.
// Used by the shared arithmetic unit, the top level and the verif files; depends on nothing.

package scqf_pkg;

   // cluster size limit and the count cap that follows from it
   localparam int MAX_WIDTH     = 256;
   localparam int COUNT_W       = 9;
   localparam int COUNT_CAP_INT = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

   // field widths
   localparam int AMP_W    = 8;
   localparam int NOISE_W  = 16;
   localparam int GAIN_W   = 16;
   localparam int CHARGE_W = 16;
   localparam int SQ_W     = 40;
   localparam int SN_W     = 24;

   // shared radix-2 unit
   localparam int ARITH_W = 40;
   localparam int OPB_W   = 16;
   localparam int REM_W   = 21;
   localparam int STEP_W  = 6;

   // iteration counts, one result bit per cycle
   localparam logic [STEP_W-1:0] STEPS_NOISE  = STEP_W'(28);
   localparam logic [STEP_W-1:0] STEPS_SQUARE = STEP_W'(16);
   localparam logic [STEP_W-1:0] STEPS_MEAN   = STEP_W'(40);
   localparam logic [STEP_W-1:0] STEPS_ROOT   = STEP_W'(20);
   localparam logic [STEP_W-1:0] STEPS_RATIO  = STEP_W'(32);

   // register bus
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_CUT_ENABLE  = 3'd0,
      CSR_STON_LOWER  = 3'd1,
      CSR_STON_UPPER  = 3'd2,
      CSR_WIDTH_LOWER = 3'd3,
      CSR_WIDTH_UPPER = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_SQRT = 2'd1,
      OP_MUL  = 2'd2
   } arith_op_type;

   typedef struct packed {
      logic                start;
      arith_op_type        op;
      logic [STEP_W-1:0]   steps;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_STRIP,
      S_NOISE,
      S_SQUARE,
      S_CLOSE,
      S_MEAN,
      S_ROOT,
      S_SCALE,
      S_RATIO,
      S_EMIT
   } state_type;

endpackage

@@ hdl/strip_cluster_quality_filter.sv @@
// Top level of the strip cluster quality filter: request handshakes, register
// bus, cluster accumulators and sequencer. Depends on scqf_pkg, scqf_arith.

// Strips of one cluster arrive one request at a time; the request flagged
// last_strip closes the cluster and yields one response with charge, width,
// RMS noise, S/N and the accept flag. All divisions, the square root and the
// squaring go through one shared radix-2 unit producing one bit per cycle,
// and that unit sets the rate: a zero-amplitude strip (or one past the width
// cap) uses no unit step, a nonzero bad strip a 16-bit squaring, and a
// nonzero good strip a 28-bit noise-over-gain divide plus the squaring.
// Closing a cluster adds a 40-bit mean divide, a 20-step root and a 32-bit
// S/N divide. One strip is in work at a time; a finished response waits in
// its output register while the next strip is taken. No reset sweep is
// needed; the block comes out of reset ready, in its idle state.

module strip_cluster_quality_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   // strip requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [scqf_pkg::AMP_W-1:0]           req_amplitude,
   input  logic [scqf_pkg::NOISE_W-1:0]         req_strip_noise,
   input  logic [scqf_pkg::GAIN_W-1:0]          req_strip_gain,
   input  logic                                 req_strip_bad,
   input  logic                                 req_last_strip,
   // cluster responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scqf_pkg::CHARGE_W-1:0]        rsp_cluster_charge,
   output logic [scqf_pkg::COUNT_W-1:0]         rsp_cluster_width,
   output logic [scqf_pkg::NOISE_W-1:0]         rsp_cluster_noise,
   output logic [scqf_pkg::SN_W-1:0]            rsp_signal_to_noise,
   output logic                                 rsp_accepted,
   // register bus
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [scqf_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [scqf_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [scqf_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import scqf_pkg::*;

   // configuration
   logic                 cut_en_ff;
   logic [SN_W-1:0]      ston_lower_ff, ston_upper_ff;
   logic [COUNT_W-1:0]   width_lower_ff, width_upper_ff;
   csr_index_type        csr_idx;
   logic                 csr_write;

   // sequencer and cluster state
   state_type            state_ff, state_in;
   logic [CHARGE_W-1:0]  charge_ff, charge_in;
   logic [SQ_W-1:0]      square_ff, square_in;
   logic [COUNT_W-1:0]   nz_ff, nz_in;
   logic [COUNT_W-1:0]   sc_ff, sc_in;
   logic [NOISE_W-1:0]   held_ff, held_in;
   logic                 work_ff, work_in;
   logic [NOISE_W-1:0]   rms_ff, rms_in;
   logic [SN_W-1:0]      sn_ff, sn_in;
   logic                 snok_ff, snok_in;

   // latched strip
   logic [AMP_W-1:0]     amp_ff;
   logic [NOISE_W-1:0]   noise_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic                 bad_ff;
   logic                 last_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 load_rsp;
   logic [CHARGE_W-1:0]  out_charge_ff;
   logic [COUNT_W-1:0]   out_width_ff;
   logic [NOISE_W-1:0]   out_noise_ff;
   logic [SN_W-1:0]      out_sn_ff;
   logic                 out_acc_ff;
   logic                 accept_now;

   // shared unit
   arith_cmd_type        arith_cmd;
   arith_stat_type       arith_stat;
   logic [ARITH_W-1:0]   arith_opa;
   logic [OPB_W-1:0]     arith_opb;
   logic [ARITH_W-1:0]   arith_res;

   logic [CHARGE_W:0]    charge_sum;
   logic [SQ_W:0]        square_sum;

   scqf_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .opa    (arith_opa),
      .opb    (arith_opb),
      .stat   (arith_stat),
      .result (arith_res)
   );

   // register bus
   assign pready    = 1'b1;
   assign csr_idx   = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_en_ff      <= 1'b0;
         ston_lower_ff  <= '0;
         ston_upper_ff  <= '1;
         width_lower_ff <= '0;
         width_upper_ff <= COUNT_W'(256);
      end else if (csr_write) begin
         case (csr_idx)
            CSR_CUT_ENABLE:  cut_en_ff      <= pwdata[0];
            CSR_STON_LOWER:  ston_lower_ff  <= pwdata[SN_W-1:0];
            CSR_STON_UPPER:  ston_upper_ff  <= pwdata[SN_W-1:0];
            CSR_WIDTH_LOWER: width_lower_ff <= pwdata[COUNT_W-1:0];
            CSR_WIDTH_UPPER: width_upper_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_CUT_ENABLE:  prdata = CSR_DATA_W'(cut_en_ff);
         CSR_STON_LOWER:  prdata = CSR_DATA_W'(ston_lower_ff);
         CSR_STON_UPPER:  prdata = CSR_DATA_W'(ston_upper_ff);
         CSR_WIDTH_LOWER: prdata = CSR_DATA_W'(width_lower_ff);
         CSR_WIDTH_UPPER: prdata = CSR_DATA_W'(width_upper_ff);
         default:         prdata = '0;
      endcase
   end

   // saturating adders
   assign charge_sum = {1'b0, charge_ff} + (CHARGE_W+1)'(req_amplitude);
   assign square_sum = {1'b0, square_ff} + (SQ_W+1)'(arith_res[31:0]);

   assign req_ready  = (state_ff == S_IDLE);
   assign accept_now = !cut_en_ff ||
                       (snok_ff && (width_lower_ff <= sc_ff) && (sc_ff <= width_upper_ff));

   // sequencer: next state, unit commands and accumulator updates
   always_comb begin
      state_in     = state_ff;
      arith_cmd    = '{start: 1'b0, op: OP_DIV, steps: '0};
      arith_opa    = '0;
      arith_opb    = '0;
      charge_in    = charge_ff;
      square_in    = square_ff;
      nz_in        = nz_ff;
      sc_in        = sc_ff;
      held_in      = held_ff;
      work_in      = work_ff;
      rms_in       = rms_ff;
      sn_in        = sn_ff;
      snok_in      = snok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load_rsp     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_STRIP;
               work_in  = 1'b0;
               if (sc_ff < COUNT_CAP) begin
                  sc_in = sc_ff + COUNT_W'(1);
                  if (req_amplitude != '0) begin
                     charge_in = charge_sum[CHARGE_W] ? '1 : charge_sum[CHARGE_W-1:0];
                     nz_in     = nz_ff + COUNT_W'(1);
                     work_in   = 1'b1;
                  end
               end
            end
         end
         S_STRIP: begin
            if (work_ff && !bad_ff) begin
               // noise * 4096 / gain, left-aligned 28-bit dividend
               arith_cmd = '{start: 1'b1, op: OP_DIV, steps: STEPS_NOISE};
               arith_opa = {noise_ff, 24'd0};
               arith_opb = gain_ff;
               state_in  = S_NOISE;
            end else if (work_ff) begin
               // bad strip reuses the held value
               arith_cmd = '{start: 1'b1, op: OP_MUL, steps: STEPS_SQUARE};
               arith_opa = {held_ff, 24'd0};
               arith_opb = held_ff;
               state_in  = S_SQUARE;
            end else if (last_ff) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NOISE: begin
            if (arith_stat.done) begin
               held_in   = (arith_res[27:16] != '0) ? '1 : arith_res[15:0];
               arith_cmd = '{start: 1'b1, op: OP_MUL, steps: STEPS_SQUARE};
               arith_opa = {held_in, 24'd0};
               arith_opb = held_in;
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (arith_stat.done) begin
               square_in = square_sum[SQ_W] ? '1 : square_sum[SQ_W-1:0];
               state_in  = last_ff ? S_CLOSE : S_IDLE;
            end
         end
         S_CLOSE: begin
            if (nz_ff != '0) begin
               // mean square
               arith_cmd = '{start: 1'b1, op: OP_DIV, steps: STEPS_MEAN};
               arith_opa = square_ff;
               arith_opb = OPB_W'(nz_ff);
               state_in  = S_MEAN;
            end else begin
               rms_in   = '0;
               state_in = S_SCALE;
            end
         end
         S_MEAN: begin
            if (arith_stat.done) begin
               arith_cmd = '{start: 1'b1, op: OP_SQRT, steps: STEPS_ROOT};
               arith_opa = arith_res;
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            if (arith_stat.done) begin
               rms_in   = (arith_res[19:16] != '0) ? '1 : arith_res[15:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (rms_ff == '0) begin
               // zero noise: infinite S/N unless the charge is zero too
               sn_in    = (charge_ff != '0) ? '1 : '0;
               snok_in  = (charge_ff == '0);
               state_in = S_EMIT;
            end else begin
               arith_cmd = '{start: 1'b1, op: OP_DIV, steps: STEPS_RATIO};
               arith_opa = {charge_ff, 24'd0};
               arith_opb = rms_ff;
               state_in  = S_RATIO;
            end
         end
         S_RATIO: begin
            if (arith_stat.done) begin
               sn_in    = (arith_res[31:24] != '0) ? '1 : arith_res[SN_W-1:0];
               snok_in  = (sn_in >= ston_lower_ff) && (sn_in <= ston_upper_ff);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               charge_in    = '0;
               square_in    = '0;
               nz_in        = '0;
               sc_in        = '0;
               held_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and cluster state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         charge_ff    <= '0;
         square_ff    <= '0;
         nz_ff        <= '0;
         sc_ff        <= '0;
         held_ff      <= '0;
         work_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         charge_ff    <= charge_in;
         square_ff    <= square_in;
         nz_ff        <= nz_in;
         sc_ff        <= sc_in;
         held_ff      <= held_in;
         work_ff      <= work_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rms_ff  <= rms_in;
      sn_ff   <= sn_in;
      snok_ff <= snok_in;
      if (req_valid && req_ready) begin
         amp_ff   <= req_amplitude;
         noise_ff <= req_strip_noise;
         gain_ff  <= req_strip_gain;
         bad_ff   <= req_strip_bad;
         last_ff  <= req_last_strip;
      end
      if (load_rsp) begin
         out_charge_ff <= charge_ff;
         out_width_ff  <= sc_ff;
         out_noise_ff  <= rms_ff;
         out_sn_ff     <= sn_ff;
         out_acc_ff    <= accept_now;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cluster_charge  = out_charge_ff;
   assign rsp_cluster_width   = out_width_ff;
   assign rsp_cluster_noise   = out_noise_ff;
   assign rsp_signal_to_noise = out_sn_ff;
   assign rsp_accepted        = out_acc_ff;

   // checks
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      arith_cmd.start |-> !arith_stat.busy)
      else $error("arith unit started while busy");

   a_counts_ordered: assert property (@(posedge clock) disable iff (reset)
      (nz_ff <= sc_ff) && (sc_ff <= COUNT_CAP))
      else $error("strip counts out of order or above cap");

   a_amp_latched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STRIP && work_ff) |-> (amp_ff != '0))
      else $error("zero amplitude strip marked for work");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_EMIT))
      else $error("response overwritten before taken");

   a_cluster_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (sc_ff == '0 && square_ff == '0 && charge_ff == '0 && rsp_valid_ff))
      else $error("cluster state not cleared after response");

endmodule

@@ hdl/scqf_arith.sv @@
// Shared bit-serial arithmetic unit: restoring divide, digit-by-digit square
// root and shift-add multiply, one result bit per cycle. Depends on scqf_pkg.

module scqf_arith (
   input  logic                            clock,
   input  logic                            reset,
   input  scqf_pkg::arith_cmd_type         cmd,
   input  logic [scqf_pkg::ARITH_W-1:0]    opa,
   input  logic [scqf_pkg::OPB_W-1:0]      opb,
   output scqf_pkg::arith_stat_type        stat,
   output logic [scqf_pkg::ARITH_W-1:0]    result
);
   import scqf_pkg::*;

   logic [ARITH_W-1:0] rad_ff, rad_in;
   logic [ARITH_W-1:0] res_ff, res_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [OPB_W-1:0]   div_ff;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   arith_op_type       op_ff;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // shared trial subtract
   logic [REM_W+1:0]   trial;
   logic [REM_W+1:0]   subtrahend;
   logic [REM_W+2:0]   diff;
   logic               fits;
   logic [31:0]        prod;

   always_comb begin
      case (op_ff)
         OP_SQRT: begin
            trial      = {rem_ff, rad_ff[ARITH_W-1 -: 2]};
            subtrahend = {1'b0, res_ff[19:0], 2'b01};
         end
         default: begin
            trial      = {1'b0, rem_ff, rad_ff[ARITH_W-1]};
            subtrahend = (REM_W+2)'(div_ff);
         end
      endcase
      diff = {1'b0, trial} - {1'b0, subtrahend};
      fits = ~diff[REM_W+2];
      // multiply: MSB-first shift and add
      prod = {res_ff[30:0], 1'b0} + (rad_ff[ARITH_W-1] ? 32'(div_ff) : 32'd0);
   end

   // one step per busy cycle
   always_comb begin
      rad_in  = rad_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rad_in  = opa;
         res_in  = '0;
         rem_in  = '0;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (op_ff)
            OP_DIV: begin
               rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
               res_in = {res_ff[ARITH_W-2:0], fits};
               rad_in = {rad_ff[ARITH_W-2:0], 1'b0};
            end
            OP_SQRT: begin
               rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
               res_in = {res_ff[ARITH_W-2:0], fits};
               rad_in = {rad_ff[ARITH_W-3:0], 2'b00};
            end
            OP_MUL: begin
               res_in = {8'd0, prod};
               rad_in = {rad_ff[ARITH_W-2:0], 1'b0};
            end
            default: begin
               res_in = res_ff;
            end
         endcase
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and result shift registers
   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      if (cmd.start) begin
         div_ff <= opb;
         op_ff  <= cmd.op;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

@@ verif/cluster_result_checker.sv @@
// Checker for the strip cluster quality filter: watches the strip requests, the
// cluster responses and the register bus, predicts every response and compares.
// Depends on scqf_pkg.

module cluster_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   // strip requests
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [scqf_pkg::AMP_W-1:0]      req_amplitude,
   input  logic [scqf_pkg::NOISE_W-1:0]    req_strip_noise,
   input  logic [scqf_pkg::GAIN_W-1:0]     req_strip_gain,
   input  logic                            req_strip_bad,
   input  logic                            req_last_strip,
   // cluster responses
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [scqf_pkg::CHARGE_W-1:0]   rsp_cluster_charge,
   input  logic [scqf_pkg::COUNT_W-1:0]    rsp_cluster_width,
   input  logic [scqf_pkg::NOISE_W-1:0]    rsp_cluster_noise,
   input  logic [scqf_pkg::SN_W-1:0]       rsp_signal_to_noise,
   input  logic                            rsp_accepted,
   // register bus
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [scqf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scqf_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [scqf_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   // towards the test top
   output int                              failures,
   output int                              clusters_outstanding
);
   import scqf_pkg::*;

   typedef struct packed {
      logic [CHARGE_W-1:0] charge;
      logic [COUNT_W-1:0]  width;
      logic [NOISE_W-1:0]  noise;
      logic [SN_W-1:0]     ston;
      logic                accepted;
   } cluster_summary_type;

   localparam logic [SN_W-1:0] STON_SATURATED = '1;

   // shadow copies of the registers
   logic                cut_enable;
   logic [SN_W-1:0]     ston_min;
   logic [SN_W-1:0]     ston_max;
   logic [COUNT_W-1:0]  width_min;
   logic [COUNT_W-1:0]  width_max;

   // cluster accumulators
   logic [CHARGE_W-1:0] charge_acc;
   logic [SQ_W-1:0]     square_acc;
   logic [COUNT_W-1:0]  nonzero_strips;
   logic [COUNT_W-1:0]  strips_taken;
   logic [NOISE_W-1:0]  held_ratio;

   cluster_summary_type expected_clusters[$];

   // working values
   logic [NOISE_W+11:0] ratio_full;
   logic [CHARGE_W:0]   charge_next;
   logic [SQ_W:0]       square_next;
   logic [SQ_W-1:0]     mean_square;
   logic [20:0]         root;
   logic [20:0]         trial;
   logic [31:0]         ston_full;
   logic                ston_pass;
   logic [31:0]         register_value;
   logic                register_known;
   cluster_summary_type want;
   cluster_summary_type seen;
   int                  bit_pos;
   int                  responses_seen = 0;
   int                  error_count = 0;

   assign failures = error_count;

   // only the first ten failures are printed
   function automatic void note_failure(input string message);
      if (error_count < 10) begin
         $display("%s", message);
      end
      error_count++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cut_enable = 1'b0;
         ston_min = '0;
         ston_max = STON_SATURATED;
         width_min = '0;
         width_max = COUNT_W'(256);
         charge_acc = '0;
         square_acc = '0;
         nonzero_strips = '0;
         strips_taken = '0;
         held_ratio = '0;
         expected_clusters.delete();
      end else begin
         // register bus: follow writes, check reads against the shadow copies
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (csr_index_type'(paddr[CSR_ADDR_W-1:2]))
                  CSR_CUT_ENABLE:  cut_enable = pwdata[0];
                  CSR_STON_LOWER:  ston_min = pwdata[SN_W-1:0];
                  CSR_STON_UPPER:  ston_max = pwdata[SN_W-1:0];
                  CSR_WIDTH_LOWER: width_min = pwdata[COUNT_W-1:0];
                  CSR_WIDTH_UPPER: width_max = pwdata[COUNT_W-1:0];
                  default: ;
               endcase
            end else begin
               register_known = 1'b1;
               register_value = '0;
               case (csr_index_type'(paddr[CSR_ADDR_W-1:2]))
                  CSR_CUT_ENABLE:  register_value = 32'(cut_enable);
                  CSR_STON_LOWER:  register_value = 32'(ston_min);
                  CSR_STON_UPPER:  register_value = 32'(ston_max);
                  CSR_WIDTH_LOWER: register_value = 32'(width_min);
                  CSR_WIDTH_UPPER: register_value = 32'(width_max);
                  default:         register_known = 1'b0;
               endcase
               if (register_known && prdata !== register_value) begin
                  note_failure($sformatf("register read at %h: expected %h, got %h",
                                         paddr, register_value, prdata));
               end
            end
         end

         // responses against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_cluster_charge, rsp_cluster_width, rsp_cluster_noise,
                    rsp_signal_to_noise, rsp_accepted};
            if (expected_clusters.size() == 0) begin
               note_failure($sformatf("response %0d with no cluster pending: charge %0d width %0d",
                                      responses_seen, seen.charge, seen.width));
            end else begin
               want = expected_clusters.pop_front();
               if (seen.charge !== want.charge || seen.width !== want.width ||
                   seen.noise !== want.noise || seen.ston !== want.ston ||
                   seen.accepted !== want.accepted) begin
                  note_failure($sformatf({"response %0d: expected charge %0d width %0d ",
                                          "noise %h s/n %h acc %b, got charge %0d width %0d ",
                                          "noise %h s/n %h acc %b"},
                                         responses_seen, want.charge, want.width, want.noise,
                                         want.ston, want.accepted, seen.charge, seen.width,
                                         seen.noise, seen.ston, seen.accepted));
               end
            end
            responses_seen++;
         end

         // strip request: accumulate, and on the last strip predict the response
         if (req_valid && req_ready) begin
            if (strips_taken < COUNT_CAP) begin
               strips_taken++;
               if (req_amplitude != 0) begin
                  charge_next = {1'b0, charge_acc} + (CHARGE_W+1)'(req_amplitude);
                  charge_acc = charge_next[CHARGE_W] ? '1 : charge_next[CHARGE_W-1:0];
                  // good strip reloads noise over gain, bad strip keeps the old one
                  if (!req_strip_bad) begin
                     if (req_strip_gain == 0) begin
                        held_ratio = '1;
                     end else begin
                        ratio_full = {req_strip_noise, 12'h000} / req_strip_gain;
                        held_ratio = (ratio_full > 28'hFFFF) ? '1 : ratio_full[NOISE_W-1:0];
                     end
                  end
                  square_next = {1'b0, square_acc} +
                                (SQ_W+1)'(held_ratio) * (SQ_W+1)'(held_ratio);
                  square_acc = square_next[SQ_W] ? '1 : square_next[SQ_W-1:0];
                  nonzero_strips++;
               end
            end

            if (req_last_strip) begin
               want.charge = charge_acc;
               want.width = strips_taken;
               // RMS: floor of the mean square, then floor of its root
               mean_square = (nonzero_strips == 0) ? '0 : square_acc / nonzero_strips;
               root = '0;
               for (bit_pos = 20; bit_pos >= 0; bit_pos--) begin
                  trial = root | (21'd1 << bit_pos);
                  if (64'(trial) * 64'(trial) <= 64'(mean_square)) begin
                     root = trial;
                  end
               end
               want.noise = (root > 21'hFFFF) ? '1 : root[NOISE_W-1:0];
               // zero noise: infinite S/N fails unless there is no charge either
               if (want.noise == 0) begin
                  want.ston = (charge_acc != 0) ? STON_SATURATED : '0;
                  ston_pass = (charge_acc == 0);
               end else begin
                  ston_full = {charge_acc, 16'h0000} / want.noise;
                  want.ston = (ston_full > 32'(STON_SATURATED)) ? STON_SATURATED
                                                                : ston_full[SN_W-1:0];
                  ston_pass = (want.ston >= ston_min) && (want.ston <= ston_max);
               end
               want.accepted = !cut_enable ||
                               (ston_pass && strips_taken >= width_min &&
                                strips_taken <= width_max);
               expected_clusters.push_back(want);
               charge_acc = '0;
               square_acc = '0;
               nonzero_strips = '0;
               strips_taken = '0;
               held_ratio = '0;
            end
         end
      end
      clusters_outstanding <= expected_clusters.size();
   end

endmodule

@@ verif/strip_cluster_quality_filter_test.sv @@
// Test top for the strip cluster quality filter: clock, reset, strip requests,
// response back-pressure and register set-up; checking sits in cluster_result_checker.
// Depends on scqf_pkg, the filter RTL and cluster_result_checker.

module strip_cluster_quality_filter_test;
   import scqf_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int SETTLE_CYCLES    = 160;   // slowest strip plus cluster close
   localparam int LONG_STALL       = 2500;
   localparam int STRIPS_PER_PHASE = 250;
   localparam int PHASES           = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [AMP_W-1:0]      req_amplitude = '0;
   logic [NOISE_W-1:0]    req_strip_noise = '0;
   logic [GAIN_W-1:0]     req_strip_gain = '0;
   logic                  req_strip_bad = 1'b0;
   logic                  req_last_strip = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHARGE_W-1:0]   rsp_cluster_charge;
   logic [COUNT_W-1:0]    rsp_cluster_width;
   logic [NOISE_W-1:0]    rsp_cluster_noise;
   logic [SN_W-1:0]       rsp_signal_to_noise;
   logic                  rsp_accepted;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int send_idle_pct = 36;
   int recv_idle_pct = 47;
   int stalls_requested = 0;
   int stalls_granted = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatches;
   int clusters_outstanding;

   strip_cluster_quality_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_amplitude(req_amplitude), .req_strip_noise(req_strip_noise),
      .req_strip_gain(req_strip_gain), .req_strip_bad(req_strip_bad),
      .req_last_strip(req_last_strip),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cluster_charge(rsp_cluster_charge), .rsp_cluster_width(rsp_cluster_width),
      .rsp_cluster_noise(rsp_cluster_noise), .rsp_signal_to_noise(rsp_signal_to_noise),
      .rsp_accepted(rsp_accepted),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cluster_result_checker cluster_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_amplitude(req_amplitude), .req_strip_noise(req_strip_noise),
      .req_strip_gain(req_strip_gain), .req_strip_bad(req_strip_bad),
      .req_last_strip(req_last_strip),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cluster_charge(rsp_cluster_charge), .rsp_cluster_width(rsp_cluster_width),
      .rsp_cluster_noise(rsp_cluster_noise), .rsp_signal_to_noise(rsp_signal_to_noise),
      .rsp_accepted(rsp_accepted),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .failures(mismatches), .clusters_outstanding(clusters_outstanding)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: random back-pressure, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_granted != stalls_requested) begin
         stalls_granted <= stalls_granted + 1;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one strip request, with a random gap in front of it
   task automatic send_strip(input logic [AMP_W-1:0] amp, input logic [NOISE_W-1:0] noise,
                             input logic [GAIN_W-1:0] gain, input logic bad,
                             input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_amplitude <= amp;
      req_strip_noise <= noise;
      req_strip_gain <= gain;
      req_strip_bad <= bad;
      req_last_strip <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // random cluster; long runs can hit the width cap and are mostly empty strips
   task automatic send_cluster(input bit long_run, output int strips);
      logic [AMP_W-1:0]   amp;
      logic [NOISE_W-1:0] noise;
      logic [GAIN_W-1:0]  gain;
      strips = long_run ? $urandom_range(250, 270) : $urandom_range(1, 6);
      for (int i = 0; i < strips; i++) begin
         case ($urandom_range(9))
            0, 1:    amp = '0;
            2:       amp = '1;
            3:       amp = AMP_W'(1);
            default: amp = AMP_W'($urandom_range(1, 255));
         endcase
         if (long_run && $urandom_range(7) != 0) begin
            amp = '0;
         end
         case ($urandom_range(9))
            0:       noise = '0;
            1:       noise = NOISE_W'($urandom_range(0, 65535));
            2:       noise = '1;
            default: noise = NOISE_W'($urandom_range(16'h0100, 16'h0800));
         endcase
         case ($urandom_range(9))
            0:       gain = '0;
            1:       gain = GAIN_W'($urandom_range(0, 65535));
            2:       gain = '1;
            3:       gain = GAIN_W'(1);
            default: gain = GAIN_W'($urandom_range(16'h0C00, 16'h1400));
         endcase
         send_strip(amp, noise, gain, $urandom_range(9) == 0, i == strips - 1);
      end
   endtask

   // stop sending and let every pending cluster come out
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (clusters_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one bus transfer; the bus stays selected until released by the caller
   task automatic bus_transfer(input logic write, input csr_index_type index,
                               input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic read_registers();
      bus_transfer(1'b0, CSR_CUT_ENABLE, '0);
      bus_transfer(1'b0, CSR_STON_LOWER, '0);
      bus_transfer(1'b0, CSR_STON_UPPER, '0);
      bus_transfer(1'b0, CSR_WIDTH_LOWER, '0);
      bus_transfer(1'b0, CSR_WIDTH_UPPER, '0);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(input logic enable, input logic [31:0] ston_lo,
                            input logic [31:0] ston_hi, input logic [31:0] width_lo,
                            input logic [31:0] width_hi);
      bus_transfer(1'b1, CSR_CUT_ENABLE, 32'(enable));
      bus_transfer(1'b1, CSR_STON_LOWER, ston_lo);
      bus_transfer(1'b1, CSR_STON_UPPER, ston_hi);
      bus_transfer(1'b1, CSR_WIDTH_LOWER, width_lo);
      bus_transfer(1'b1, CSR_WIDTH_UPPER, width_hi);
      read_registers();
   endtask

   initial begin
      int strips;
      int phase_strips;
      bit stall_asked;
      stall_asked = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      read_registers();

      // directed clusters, cut disabled
      send_strip(8'd255, 16'hFFFF, 16'h0001, 1'b0, 1'b1);   // ratio saturates
      send_strip(8'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);     // no charge, no noise
      send_strip(8'd10, 16'h0400, 16'h1000, 1'b1, 1'b0);    // bad before any good strip
      send_strip(8'd20, 16'h0200, 16'h1000, 1'b0, 1'b1);
      send_strip(8'd1, 16'h1234, 16'h0000, 1'b0, 1'b1);     // zero gain
      send_strip(8'd200, 16'h0000, 16'h1000, 1'b0, 1'b1);   // charge with zero noise
      send_strip(8'd50, 16'h0300, 16'h1000, 1'b0, 1'b0);    // bad reuses last good ratio
      send_strip(8'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_strip(8'd60, 16'h0100, 16'h0800, 1'b1, 1'b0);
      send_strip(8'd70, 16'h0500, 16'h2000, 1'b0, 1'b1);
      send_strip(8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_strip(8'd255, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_strip(8'd128, 16'h0001, 16'hFFFF, 1'b0, 1'b1);
      send_strip(8'd0, 16'h0000, 16'h0000, 1'b0, 1'b0);     // two empty strips
      send_strip(8'd0, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_strip(8'd1, 16'h0100, 16'h1000, 1'b0, 1'b1);
      send_strip(8'd255, 16'h0010, 16'hFFFF, 1'b0, 1'b0);   // S/N saturates
      send_strip(8'd255, 16'h0010, 16'hFFFF, 1'b0, 1'b1);
      wait_until_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0, 1: begin
               send_idle_pct = 36;
               recv_idle_pct = 47;
            end
            2, 3: begin
               send_idle_pct = 47;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: configure(1'b1, $urandom_range(0, 4000), $urandom_range(6000, 40000),
                         $urandom_range(0, 2), $urandom_range(3, 8));
            1: configure(1'b1, 32'hFF_FFFF, 32'h0, 32'd256, 32'd0);   // crossed windows
            2: configure(1'b1, 32'h0, 32'hFF_FFFF, 32'd0, 32'd256);   // widest windows
            3: configure(1'b1, 32'h0, 32'hFF_FFFF, 32'd256, 32'd256); // only capped clusters
            4: configure(1'b0, $urandom_range(0, 20000), $urandom_range(0, 20000),
                         $urandom_range(0, 256), $urandom_range(0, 256));
            default: configure(1'b1, $urandom_range(0, 20000), $urandom_range(20000, 60000),
                               $urandom_range(1, 3), $urandom_range(2, 256));
         endcase
         phase_strips = 0;
         while (phase_strips < STRIPS_PER_PHASE) begin
            // long receiver hold-off while strips keep coming
            if (phase == 2 && !stall_asked && phase_strips >= 40) begin
               stalls_requested++;
               stall_asked = 1'b1;
            end
            send_cluster($urandom_range(phase == 3 ? 8 : 40) == 0, strips);
            phase_strips += strips;
         end
         wait_until_idle();
      end

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ strip_cluster_quality_filter.f @@
hdl/scqf_pkg.sv
hdl/scqf_arith.sv
hdl/strip_cluster_quality_filter.sv
verif/cluster_result_checker.sv
verif/strip_cluster_quality_filter_test.sv
